// ----- hw/rtl/jsd_pkg.sv -----
// Package for the jiggle spring-damper step core: register indexes, reset values and widths.
// No dependencies.
package jsd_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_EN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_Y    = 3'd5;

    localparam logic [17:0] STIFFNESS_RST = 18'd768;
    localparam logic [17:0] MASS_RST      = 18'd192;
    localparam logic [16:0] DAMPING_RST   = 17'd49152;
    localparam logic [31:0] GRAV_X_RST    = 32'd0;
    localparam logic [31:0] GRAV_Y_RST    = 32'd393216;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // Saturate a 40-bit signed value to 32 bits.
    function automatic logic [32:0] sat40(input logic signed [39:0] v);
        logic [32:0] r;
        begin
            if (v > 40'sd2147483647)
                r = {1'b1, S32_MAX};
            else if (v < -40'sd2147483648)
                r = {1'b1, S32_MIN};
            else
                r = {1'b0, v[31:0]};
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/jsd_divider.sv -----
// Restoring divider, one quotient bit per cycle: 40-bit dividend by 18-bit divisor.
// Depends on nothing.
module jsd_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [17:0] divisor,
    output logic        done,
    output logic [39:0] quotient
);
    logic [39:0] q_reg, q_next;
    logic [18:0] r_reg, r_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [18:0] trial;
    logic [18:0] diff;

    assign trial = {r_reg[17:0], q_reg[39]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                r_next = diff;
                q_next = {q_reg[38:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd39)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

// ----- hw/rtl/jiggle_spring_damper_step_core.sv -----
// Jiggle spring-damper step core: per-joint velocity and last origin, one result per item.
// Depends on jsd_pkg and jsd_divider.
// Sequence per item: kdt, then per axis force, gravity when enabled, a bit-serial divide by
// mass (skipped with zero mass), damping and position; the result then goes to the output.
// A new item is accepted only once the last has left the sequencer; a result still waiting stalls the next.
// One shared 33x33 multiplier, one product a cycle under the sequencer.
// Reset sets the config registers to defaults and clears the joint state tables to zero.
module jiggle_spring_damper_step_core
#(
    parameter int MAX_JOINTS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [jsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jsd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // joint_index[3:0], target_x, target_y, seed_x, seed_y, origin_x, origin_y,
    // time_step[15:0] from bit 4 upward, zero pad to 216 bits
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // joint_out[3:0], position_x[35:4], position_y[67:36], zero pad to 72 bits
    output logic [71:0]  m_axis_tdata,
    // saturated
    output logic         m_axis_tuser
);
    import jsd_pkg::*;

    localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_KDT   = 4'd1;
    localparam logic [3:0] ST_FORCE = 4'd2;
    localparam logic [3:0] ST_GRAV  = 4'd3;
    localparam logic [3:0] ST_DIVS  = 4'd4;
    localparam logic [3:0] ST_DIVW  = 4'd5;
    localparam logic [3:0] ST_DAMP  = 4'd6;
    localparam logic [3:0] ST_POS   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [17:0] stiff_reg, mass_reg;
    logic [16:0] damp_reg;
    logic        gen_reg;
    logic [31:0] gx_reg, gy_reg;

    logic [3:0]  state_reg, state_next;
    logic        axis_reg, axis_next;
    logic [215:0] item_reg;
    logic [27:0] kdt_reg, kdt_next;
    logic signed [31:0] force_reg, force_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [31:0] px_reg, px_next;
    logic [31:0] py_reg;
    logic        flag_reg, flag_next;
    logic [71:0] out_reg;
    logic        out_flag_reg;
    logic        ovalid_reg, ovalid_next;
    logic        out_load;

    logic signed [31:0] vel_x_reg [MAX_JOINTS];
    logic signed [31:0] vel_y_reg [MAX_JOINTS];
    logic signed [31:0] lo_x_reg  [MAX_JOINTS];
    logic signed [31:0] lo_y_reg  [MAX_JOINTS];

    logic [3:0]  jidx;
    logic        jok;
    logic [JW-1:0] jsel;
    logic signed [31:0] tgt, seed, org, grav, vold, lold;
    logic [15:0] dt;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [65:0] prod_rnd;
    logic signed [49:0] shifted;
    logic [32:0] sat_r;

    logic        div_start, div_done;
    logic [39:0] div_q;
    logic [31:0] fmag;
    logic [16:0] dcl;
    logic [16:0] keep;
    logic signed [40:0] qs;
    logic [32:0] pos_sat;
    logic write_state;

    assign jidx = item_reg[3:0];
    assign jok  = ({28'd0, jidx} < MAX_JOINTS);
    assign jsel = JW'(jidx);
    assign dt   = item_reg[211:196];
    assign tgt  = axis_reg ? item_reg[67:36]   : item_reg[35:4];
    assign seed = axis_reg ? item_reg[131:100] : item_reg[99:68];
    assign org  = axis_reg ? item_reg[195:164] : item_reg[163:132];
    assign grav = axis_reg ? gy_reg : gx_reg;
    assign vold = !jok ? 32'sd0 : (axis_reg ? vel_y_reg[jsel] : vel_x_reg[jsel]);
    assign lold = !jok ? 32'sd0 : (axis_reg ? lo_y_reg[jsel] : lo_x_reg[jsel]);

    assign dcl  = damp_reg[16] ? 17'd65536 : damp_reg;
    assign keep = 17'd65536 - dcl;
    assign fmag = force_reg[31] ? (32'd0 - force_reg) : force_reg;

    assign out_load = (state_reg == ST_OUT) && (!ovalid_reg || m_axis_tready);

    always_comb
    begin
        unique case (state_reg)
            ST_KDT:
            begin
                mul_a = {15'd0, stiff_reg};
                mul_b = {17'd0, dt};
            end
            ST_FORCE:
            begin
                mul_a = {tgt[31], tgt} - {seed[31], seed};
                mul_b = {5'd0, kdt_reg};
            end
            ST_GRAV:
            begin
                mul_a = {grav[31], grav};
                mul_b = {17'd0, dt};
            end
            ST_DAMP:
            begin
                mul_a = {acc_reg[31], acc_reg};
                mul_b = {16'd0, keep};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_rnd = prod + 66'sd32768;
    assign shifted  = prod_rnd[65:16];
    assign sat_r    = (shifted > 50'sd2147483647) ? {1'b1, S32_MAX} :
                      (shifted < -50'sd2147483648) ? {1'b1, S32_MIN} :
                      {1'b0, shifted[31:0]};

    assign qs = force_reg[31] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    assign pos_sat = sat40(40'(seed) + 40'(vel_reg) + 40'(force_reg) + 40'(org) - 40'(lold));

    jsd_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({fmag, 8'd0}),
        .divisor  (mass_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        kdt_next    = kdt_reg;
        force_next  = force_reg;
        acc_next    = acc_reg;
        vel_next    = vel_reg;
        px_next     = px_reg;
        flag_next   = flag_reg;
        ovalid_next = ovalid_reg;
        div_start   = 1'b0;
        write_state = 1'b0;
        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_KDT;
                    axis_next  = 1'b0;
                    flag_next  = 1'b0;
                end
            end
            ST_KDT:
            begin
                kdt_next   = prod[35:8];
                state_next = ST_FORCE;
            end
            ST_FORCE:
            begin
                force_next = sat_r[31:0];
                flag_next  = flag_reg | sat_r[32];
                state_next = gen_reg ? ST_GRAV : ST_DIVS;
            end
            ST_GRAV:
            begin
                {flag_next, force_next} = sat40(40'(force_reg) + 40'($signed(sat_r[31:0])));
                flag_next  = flag_next | flag_reg;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                vel_next = vold;
                if (mass_reg == 18'd0)
                begin
                    flag_next  = 1'b1;
                    acc_next   = (force_reg == 32'sd0) ? 32'sd0 :
                                 (force_reg[31] ? S32_MIN : S32_MAX);
                    state_next = ST_DAMP;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    {flag_next, acc_next} = sat40(qs[39:0]);
                    flag_next  = flag_next | flag_reg;
                    state_next = ST_DAMP;
                end
            end
            ST_DAMP:
            begin
                {flag_next, vel_next} = sat40(40'(vel_reg) + 40'($signed(sat_r[31:0])));
                flag_next  = flag_next | flag_reg;
                state_next = ST_POS;
            end
            ST_POS:
            begin
                flag_next   = flag_reg | pos_sat[32];
                write_state = jok;
                if (!axis_reg)
                begin
                    px_next    = pos_sat[31:0];
                    axis_next  = 1'b1;
                    state_next = ST_FORCE;
                end
                else
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            stiff_reg  <= STIFFNESS_RST;
            mass_reg   <= MASS_RST;
            damp_reg   <= DAMPING_RST;
            gen_reg    <= 1'b0;
            gx_reg     <= GRAV_X_RST;
            gy_reg     <= GRAV_Y_RST;
            for (int i = 0; i < MAX_JOINTS; i++)
            begin
                vel_x_reg[i] <= '0;
                vel_y_reg[i] <= '0;
                lo_x_reg[i]  <= '0;
                lo_y_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STIFFNESS: stiff_reg <= cfg_data[17:0];
                    REG_MASS:      mass_reg  <= cfg_data[17:0];
                    REG_DAMPING:   damp_reg  <= cfg_data[16:0];
                    REG_GRAV_EN:   gen_reg   <= cfg_data[0];
                    REG_GRAV_X:    gx_reg    <= cfg_data;
                    REG_GRAV_Y:    gy_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (write_state)
            begin
                if (axis_reg)
                begin
                    vel_y_reg[jsel] <= vel_reg;
                    lo_y_reg[jsel]  <= org;
                end
                else
                begin
                    vel_x_reg[jsel] <= vel_reg;
                    lo_x_reg[jsel]  <= org;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg  <= axis_next;
        kdt_reg   <= kdt_next;
        force_reg <= force_next;
        acc_reg   <= acc_next;
        vel_reg   <= vel_next;
        px_reg    <= px_next;
        flag_reg  <= flag_next;
        if (state_reg == ST_IDLE && s_axis_tvalid)
            item_reg <= s_axis_tdata;
        if (state_reg == ST_POS && axis_reg)
            py_reg <= pos_sat[31:0];
        if (out_load)
        begin
            out_reg      <= {4'd0, py_reg, px_reg, jidx};
            out_flag_reg <= flag_reg;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = out_flag_reg;
endmodule

// ----- sim/jiggle_spring_damper_step_core_test.sv -----
// Testbench for jiggle_spring_damper_step_core: random and directed joint items,
// predicted in-bench and checked field by field. Depends on jsd_pkg and the core RTL.
`timescale 1ns / 100ps

module jiggle_spring_damper_step_core_test;
    import jsd_pkg::*;

    typedef struct packed {
        logic [15:0] dt;
        logic signed [31:0] oy, ox, sy, sx, ty, tx;
        logic [3:0] joint;
    } joint_item_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] py, px;
        logic [3:0]  joint;
    } joint_pos_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [215:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic m_axis_tuser;

    jiggle_spring_damper_step_core uut (.*);

    always #2 clk = ~clk;

    // predictor copy of registers and joint state
    longint stiff_r, mass_r, damp_r, gx_r, gy_r;
    bit genable_r;
    longint vel_x[16], vel_y[16], last_x[16], last_y[16];

    joint_item_t pending_items[$];
    joint_pos_t  expected_pos[$];
    int errors = 0;
    bit no_idle = 0;
    bit rx_hold = 0;
    bit hold_go = 0;
    longint cycles = 0;

    function automatic longint round_sh(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(longint x, ref bit f);
        if (x > 64'sd2147483647) begin f = 1; return 64'sd2147483647; end
        if (x < -64'sd2147483648) begin f = 1; return -64'sd2147483648; end
        return x;
    endfunction

    function automatic longint spring_axis(longint tgt, longint sd, longint org, longint g,
                                           longint dt, ref longint vel, ref longint last,
                                           ref bit f);
        longint kdt, frc, accel, keep, mag, q, pos;
        kdt = (stiff_r * dt) >>> 8;
        frc = clip32(round_sh((tgt - sd) * kdt, 16), f);
        if (genable_r)
            frc = clip32(frc + round_sh(g * dt, 16), f);
        if (mass_r == 0) begin
            f = 1;
            accel = frc > 0 ? 64'sd2147483647 : (frc < 0 ? -64'sd2147483648 : 0);
        end
        else begin
            mag = frc < 0 ? -frc : frc;
            q = (mag << 8) / mass_r;
            accel = clip32(frc < 0 ? -q : q, f);
        end
        keep = 65536 - (damp_r > 65536 ? 65536 : damp_r);
        vel = clip32(vel + round_sh(accel * keep, 16), f);
        pos = clip32(sd + vel + frc + org - last, f);
        last = org;
        return pos;
    endfunction

    function automatic joint_pos_t predict_position(joint_item_t it);
        joint_pos_t r;
        bit f = 0;
        longint vx, vy, lx, ly;
        vx = vel_x[it.joint]; vy = vel_y[it.joint];
        lx = last_x[it.joint]; ly = last_y[it.joint];
        r.px = 32'(spring_axis(it.tx, it.sx, it.ox, gx_r, longint'(it.dt), vx, lx, f));
        r.py = 32'(spring_axis(it.ty, it.sy, it.oy, gy_r, longint'(it.dt), vy, ly, f));
        vel_x[it.joint] = vx; vel_y[it.joint] = vy;
        last_x[it.joint] = lx; last_y[it.joint] = ly;
        r.joint = it.joint;
        r.sat = f;
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) begin
            expected_pos = {expected_pos,
                            predict_position(joint_item_t'(s_axis_tdata[211:0]))};
            void'(pending_items.pop_front());
        end
        if ((!s_axis_tvalid || s_axis_tready) ) begin
            if (pending_items.size() > 0
                && (no_idle || $urandom_range(99) >= 38)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'd0, pending_items[0]};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver hold-off, counted here
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (600) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        joint_pos_t got, want;
        cycles <= cycles + 1;
        m_axis_tready <= !rx_hold && (no_idle || $urandom_range(99) >= 38);
        if (m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata[67:0]};
            if (expected_pos.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: %h", $time, got);
            end
            else begin
                want = expected_pos.pop_front();
                if (got.joint !== want.joint) begin
                    errors++;
                    $display("%0t: joint exp %0d got %0d", $time, want.joint, got.joint);
                end
                if (got.px !== want.px) begin
                    errors++;
                    $display("%0t: pos x exp %h got %h", $time, want.px, got.px);
                end
                if (got.py !== want.py) begin
                    errors++;
                    $display("%0t: pos y exp %h got %h", $time, want.py, got.py);
                end
                if (got.sat !== want.sat) begin
                    errors++;
                    $display("%0t: sat exp %b got %b", $time, want.sat, got.sat);
                end
            end
        end
        if (cycles > 400000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // items are consumed by the driver only after acceptance; pop happens at accept
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_pos.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_STIFFNESS: stiff_r = longint'(val[17:0]);
            REG_MASS:      mass_r = longint'(val[17:0]);
            REG_DAMPING:   damp_r = longint'(val[16:0]);
            REG_GRAV_EN:   genable_r = val[0];
            REG_GRAV_X:    gx_r = longint'($signed(val));
            REG_GRAV_Y:    gy_r = longint'($signed(val));
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    task automatic add_item(int j, logic [31:0] tx, ty, sx, sy, ox, oy, logic [15:0] dt);
        joint_item_t it;
        it.joint = 4'(j); it.tx = tx; it.ty = ty; it.sx = sx; it.sy = sy;
        it.ox = ox; it.oy = oy; it.dt = dt;
        pending_items = {pending_items, it};
    endtask

    task automatic add_random(int n);
        repeat (n)
            add_item($urandom_range(15), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord(),
                     $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4000)));
    endtask

    initial
    begin
        stiff_r = STIFFNESS_RST; mass_r = MASS_RST; damp_r = DAMPING_RST;
        genable_r = 0; gx_r = 0; gy_r = longint'($signed(GRAV_Y_RST));
        foreach (vel_x[i])
        begin
            vel_x[i] = 0; vel_y[i] = 0; last_x[i] = 0; last_y[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // directed: extremes, zero step, full-scale step
        add_item(0, 0, 0, 0, 0, 0, 0, 0);
        add_item(15, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h80000000, 16'hffff);
        add_item(15, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                 32'h80000000, 32'h7fffffff, 16'hffff);
        add_item(3, 32'h00010000, 32'hffff0000, 0, 0, 32'h00005000, 0, 16'h1000);
        add_item(3, 32'h00010000, 32'hffff0000, 0, 0, 32'h00005000, 0, 16'h1000);
        add_random(10);
        wait_drained();
        // zero mass, gravity on at extremes
        write_reg(REG_MASS, 0);
        write_reg(REG_GRAV_EN, 1);
        write_reg(REG_GRAV_X, 32'h80000000);
        write_reg(REG_GRAV_Y, 32'h7fffffff);
        add_item(1, 32'h00020000, 0, 0, 32'h00020000, 0, 0, 16'h8000);
        add_item(2, 0, 0, 0, 0, 0, 0, 16'h0000);
        add_random(6);
        wait_drained();
        // stiffness and mass of 256000, damping above one
        write_reg(REG_STIFFNESS, 256000);
        write_reg(REG_MASS, 256000);
        write_reg(REG_DAMPING, 17'h1ffff);
        add_random(40);
        wait_drained();
        write_reg(REG_STIFFNESS, 0);
        write_reg(REG_DAMPING, 0);
        write_reg(REG_MASS, 1);
        write_reg(REG_GRAV_EN, 0);
        add_random(60);
        // receiver holds off while items keep coming
        hold_go = 1;
        wait_drained();
        write_reg(REG_STIFFNESS, 768);
        write_reg(REG_MASS, 192);
        write_reg(REG_DAMPING, 65536);
        write_reg(REG_GRAV_X, $urandom);
        write_reg(REG_GRAV_Y, $urandom);
        write_reg(REG_GRAV_EN, 1);
        no_idle = 1;
        add_random(100);
        wait_drained();
        no_idle = 0;
        write_reg(REG_DAMPING, 49152);
        write_reg(REG_GRAV_EN, 0);
        add_random(280);
        wait_drained();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- jiggle_spring_damper_step_core.f -----
hw/rtl/jsd_pkg.sv
hw/rtl/jsd_divider.sv
hw/rtl/jiggle_spring_damper_step_core.sv
sim/jiggle_spring_damper_step_core_test.sv
